/* hdl/vrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_pkg
// Shared types and fixed widths for the voxel ray caster.
// ----------------------------------------------------------------------------
package vrc_pkg;

    localparam int R_W     = 12;
    localparam int SQ_W    = 22;
    localparam int RAD_W   = 54;
    localparam int ROOT_W  = 27;
    localparam int SREM_W  = 30;
    localparam int MAG_W   = 11;
    localparam int DVD_W   = MAG_W + 32;
    localparam int DIR_W   = 18;
    localparam int POS_W   = 32;
    localparam int CNT_W   = 6;
    localparam int COLOR_W = 32;
    localparam int VOX_W   = 24;
    localparam int DEPTH_W = 10;

    localparam logic [1:0] REG_EYE_X = 2'd0;
    localparam logic [1:0] REG_EYE_Y = 2'd1;
    localparam logic [1:0] REG_EYE_Z = 2'd2;

    localparam logic ACT_CAST  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [2:0] {
        NP_IDLE,
        NP_SQ,
        NP_SQRT,
        NP_LOAD,
        NP_DIV,
        NP_DONE
    } norm_phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NORM,
        ST_ADDR,
        ST_CHECK
    } cast_state_t;

endpackage

/* hdl/voxel_ray_cast_first_hit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_cast_first_hit_top
// Voxel volume store with a first-hit ray marcher.
// ----------------------------------------------------------------------------
// After reset a clearing pass empties every word of the voxel memory; busy is
// high until it ends. A voxel write gives no result. A cast normalizes the ray
// (bit-serial square root and three divisions), then marches it with one voxel
// memory read per step, for at most MAX_STEPS steps. The result strobe lasts
// one cycle and cannot be stalled.
module voxel_ray_cast_first_hit_top
#(
    parameter int IMAGE_SIZE = 256,
    parameter int VOLUME_X   = 256,
    parameter int VOLUME_Y   = 128,
    parameter int VOLUME_Z   = 256,
    parameter int MAX_STEPS  = 600
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [7:0]                    pixel_x,
    input  logic [7:0]                    pixel_y,
    input  logic [7:0]                    voxel_x,
    input  logic [6:0]                    voxel_y,
    input  logic [7:0]                    voxel_z,
    input  logic [vrc_pkg::VOX_W-1:0]     voxel_value,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    output logic                          done,
    output logic [vrc_pkg::COLOR_W-1:0]   color,
    output logic [vrc_pkg::DEPTH_W-1:0]   depth
);
    import vrc_pkg::*;

    localparam int DEPTH = VOLUME_X * VOLUME_Y * VOLUME_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int CW    = POS_W - 17;

    logic [VOX_W-1:0]        mem_q [DEPTH];
    logic [VOX_W-1:0]        rd_data_reg;

    cast_state_t             state_reg, state_next;
    logic [7:0]              eye_x_reg, eye_y_reg, eye_z_reg;
    logic [AW-1:0]           clr_reg;
    logic [SW-1:0]           step_reg;
    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic                    done_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic [DEPTH_W-1:0]      depth_reg;

    logic signed [R_W-1:0]   rx, ry, rz;
    logic                    norm_start, norm_done;
    logic signed [DIR_W-1:0] ndx, ndy, ndz;
    logic [CW-1:0]           cx, cy, cz;
    logic                    outside;
    logic                    at_limit;
    logic                    accept;
    logic                    wr_ok;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    hit;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign rx = R_W'({4'b0, pixel_x}) - R_W'({4'b0, eye_x_reg});
    assign ry = R_W'(IMAGE_SIZE) - R_W'({4'b0, pixel_y}) - R_W'({4'b0, eye_y_reg});
    assign rz = -R_W'({4'b0, eye_z_reg});
    assign norm_start = accept && (action == ACT_CAST);

    vrc_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .rx    (rx),
        .ry    (ry),
        .rz    (rz),
        .done  (norm_done),
        .dx    (ndx),
        .dy    (ndy),
        .dz    (ndz)
    );

    assign cx = pos_reg[0][POS_W-2:16];
    assign cy = pos_reg[1][POS_W-2:16];
    assign cz = pos_reg[2][POS_W-2:16];
    assign outside = pos_reg[0][POS_W-1] || pos_reg[1][POS_W-1] || pos_reg[2][POS_W-1]
                  || (cx >= CW'(VOLUME_X)) || (cy >= CW'(VOLUME_Y)) || (cz >= CW'(VOLUME_Z));
    assign at_limit = (step_reg == SW'(MAX_STEPS));
    assign rd_addr  = AW'((AW'(cy) * AW'(VOLUME_Z) + AW'(cz)) * AW'(VOLUME_X) + AW'(cx));
    assign wr_addr  = AW'((AW'(voxel_y) * AW'(VOLUME_Z) + AW'(voxel_z)) * AW'(VOLUME_X)
                    + AW'(voxel_x));
    assign wr_ok    = ({4'b0, voxel_x} < 12'(VOLUME_X)) && ({5'b0, voxel_y} < 12'(VOLUME_Y))
                   && ({4'b0, voxel_z} < 12'(VOLUME_Z));
    assign hit      = (rd_data_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (norm_start) state_next = ST_NORM;
            ST_NORM:  if (norm_done) state_next = ST_ADDR;
            ST_ADDR:  if (!at_limit && !outside) state_next = ST_CHECK;
                      else state_next = ST_IDLE;
            ST_CHECK: state_next = hit ? ST_IDLE : ST_ADDR;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            eye_x_reg <= 8'd128;
            eye_y_reg <= 8'd80;
            eye_z_reg <= 8'd120;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            done_reg <= ((state_reg == ST_ADDR) && (at_limit || outside))
                     || ((state_reg == ST_CHECK) && hit);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_EYE_X: eye_x_reg <= cfg_data;
                    REG_EYE_Y: eye_y_reg <= cfg_data;
                    REG_EYE_Z: eye_z_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem_q[clr_reg] <= '0;
        else if (accept && (action == ACT_WRITE) && wr_ok)
            mem_q[wr_addr] <= voxel_value;
        rd_data_reg <= mem_q[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                step_reg   <= '0;
                pos_reg[0] <= POS_W'({eye_x_reg, 16'd0});
                pos_reg[1] <= POS_W'({eye_y_reg, 16'd0});
                pos_reg[2] <= POS_W'({eye_z_reg, 16'd0});
            end
            ST_NORM:
            begin
                dir_reg[0] <= ndx;
                dir_reg[1] <= ndy;
                dir_reg[2] <= ndz;
            end
            ST_ADDR:
            begin
                color_reg <= '1;
                depth_reg <= DEPTH_W'(step_reg);
            end
            ST_CHECK:
            begin
                color_reg  <= {8'hFF, rd_data_reg};
                step_reg   <= step_reg + SW'(1);
                pos_reg[0] <= pos_reg[0] + POS_W'(dir_reg[0]);
                pos_reg[1] <= pos_reg[1] + POS_W'(dir_reg[1]);
                pos_reg[2] <= pos_reg[2] + POS_W'(dir_reg[2]);
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign color = color_reg;
    assign depth = depth_reg;

endmodule

/* hdl/vrc_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_norm
// Normalizes a ray vector to a Q2.16 direction with a bit-serial square root
// and a bit-serial divider shared by the three components.
// ----------------------------------------------------------------------------
module vrc_norm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [vrc_pkg::R_W-1:0]   rx,
    input  logic signed [vrc_pkg::R_W-1:0]   ry,
    input  logic signed [vrc_pkg::R_W-1:0]   rz,
    output logic                             done,
    output logic signed [vrc_pkg::DIR_W-1:0] dx,
    output logic signed [vrc_pkg::DIR_W-1:0] dy,
    output logic signed [vrc_pkg::DIR_W-1:0] dz
);
    import vrc_pkg::*;

    norm_phase_t              phase_reg, phase_next;
    logic signed [R_W-1:0]    r_reg [3];
    logic signed [DIR_W-1:0]  d_reg [3];
    logic [RAD_W-1:0]         rad_reg;
    logic [SREM_W-1:0]        srem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               comp_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [ROOT_W:0]          drem_reg;
    logic [DIR_W-1:0]         quo_reg;

    logic [SREM_W-1:0]        srem_sh;
    logic [SREM_W-1:0]        trial;
    logic                     sge;
    logic [ROOT_W+1:0]        dr_sh;
    logic                     dge;
    logic signed [R_W-1:0]    r_cur;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          sumsq;

    assign srem_sh = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sge     = srem_sh >= trial;
    assign dr_sh   = {drem_reg, dvd_reg[DVD_W-1]};
    assign dge     = dr_sh >= {2'b00, root_reg};
    assign r_cur   = r_reg[comp_reg];
    assign mag     = r_cur[R_W-1] ? MAG_W'(-r_cur) : MAG_W'(r_cur);
    assign sumsq   = SQ_W'(r_reg[0] * r_reg[0]) + SQ_W'(r_reg[1] * r_reg[1])
                   + SQ_W'(r_reg[2] * r_reg[2]);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            NP_IDLE: if (start) phase_next = NP_SQ;
            NP_SQ:   phase_next = NP_SQRT;
            NP_SQRT: if (cnt_reg == CNT_W'(ROOT_W - 1)) phase_next = NP_LOAD;
            NP_LOAD:
            begin
                if (root_reg == '0)
                    phase_next = (comp_reg == 2'd2) ? NP_DONE : NP_LOAD;
                else
                    phase_next = NP_DIV;
            end
            NP_DIV:
            begin
                if (cnt_reg == CNT_W'(DVD_W - 1))
                    phase_next = (comp_reg == 2'd2) ? NP_DONE : NP_LOAD;
            end
            NP_DONE: phase_next = NP_IDLE;
            default: phase_next = NP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= NP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            NP_IDLE:
            begin
                r_reg[0] <= rx;
                r_reg[1] <= ry;
                r_reg[2] <= rz;
            end
            NP_SQ:
            begin
                rad_reg  <= {sumsq, 32'd0};
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                comp_reg <= 2'd0;
            end
            NP_SQRT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                srem_reg <= sge ? (srem_sh - trial) : srem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], sge};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            NP_LOAD:
            begin
                dvd_reg  <= {mag, 32'd0};
                drem_reg <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                if (root_reg == '0)
                begin
                    d_reg[comp_reg] <= '0;
                    comp_reg        <= comp_reg + 2'd1;
                end
            end
            NP_DIV:
            begin
                dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                drem_reg <= dge ? (ROOT_W+1)'(dr_sh - {2'b00, root_reg})
                                : dr_sh[ROOT_W:0];
                quo_reg  <= {quo_reg[DIR_W-2:0], dge};
                cnt_reg  <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    d_reg[comp_reg] <= r_cur[R_W-1] ? -$signed({quo_reg[DIR_W-2:0], dge})
                                                    : $signed({quo_reg[DIR_W-2:0], dge});
                    comp_reg        <= comp_reg + 2'd1;
                end
            end
            NP_DONE: ;
            default: ;
        endcase
    end

    assign done = (phase_reg == NP_DONE);
    assign dx   = d_reg[0];
    assign dy   = d_reg[1];
    assign dz   = d_reg[2];

endmodule

/* test/voxel_ray_cast_first_hit_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_cast_first_hit_top_tb
// Self-checking bench for the first-hit voxel ray caster. It loads voxels and
// casts rays under several eye settings and sender idling patterns. Each
// accepted cast is predicted by marching the same Q2.16 ray over a sparse copy
// of the volume, and every result is compared field by field.
// ----------------------------------------------------------------------------
module voxel_ray_cast_first_hit_top_tb;

    import vrc_pkg::*;

    localparam int IMG  = 256;
    localparam int VX   = 256;
    localparam int VY   = 128;
    localparam int VZ   = 256;
    localparam int STEPS = 600;

    typedef struct {
        logic        act;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  vx;
        logic [6:0]  vy;
        logic [7:0]  vz;
        logic [23:0] val;
    } cmd_t;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
    } hit_t;

    class ray_scoreboard;
        logic [7:0]  eye[3];
        logic [23:0] volume[longint];
        hit_t        expected_hits[$];
        int          errors;

        function new();
            eye[0] = 8'd128;
            eye[1] = 8'd80;
            eye[2] = 8'd120;
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned trial;
            res = 0;
            for (int b = 27; b >= 0; b--)
            begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v)
                    res = trial;
            end
            return res;
        endfunction

        function longint unit_comp(longint r, longint unsigned len);
            longint unsigned mag;
            if (len == 0)
                return 0;
            mag = (r < 0) ? -r : r;
            mag = (mag << 32) / len;
            return (r < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function void ray_dir(logic [7:0] px, logic [7:0] py, output longint d[3]);
            longint r[3];
            longint unsigned sq;
            longint unsigned len;
            r[0] = longint'(px) - longint'(eye[0]);
            r[1] = IMG - longint'(py) - longint'(eye[1]);
            r[2] = -longint'(eye[2]);
            sq = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
            len = root_floor(sq << 32);
            for (int i = 0; i < 3; i++)
                d[i] = unit_comp(r[i], len);
        endfunction

        // Voxel coordinates reached at step k, or 0 when the ray is outside.
        function bit cell_at(logic [7:0] px, logic [7:0] py, int k, output int c[3]);
            longint d[3];
            longint p;
            int lim[3];
            lim[0] = VX;
            lim[1] = VY;
            lim[2] = VZ;
            ray_dir(px, py, d);
            for (int i = 0; i < 3; i++)
            begin
                p = (longint'(eye[i]) << 16) + d[i] * k;
                if (p < 0 || (p >>> 16) >= lim[i])
                    return 0;
                c[i] = int'(p >>> 16);
            end
            return 1;
        endfunction

        function void note(cmd_t c);
            hit_t h;
            int   pos[3];
            longint key;
            int   k;
            if (c.act == ACT_WRITE)
            begin
                key = (longint'(c.vy) * VZ + c.vz) * VX + c.vx;
                volume[key] = c.val;
                return;
            end
            h.color = 32'hFFFF_FFFF;
            for (k = 0; k < STEPS; k++)
            begin
                if (!cell_at(c.px, c.py, k, pos))
                    break;
                key = (longint'(pos[1]) * VZ + pos[2]) * VX + pos[0];
                if (volume.exists(key) && volume[key] != 0)
                begin
                    h.color = {8'hFF, volume[key]};
                    break;
                end
            end
            h.depth = k[DEPTH_W-1:0];
            expected_hits.push_back(h);
        endfunction

        function void check(logic [COLOR_W-1:0] color, logic [DEPTH_W-1:0] depth);
            hit_t h;
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result color=%h depth=%0d", color, depth);
                errors++;
                return;
            end
            h = expected_hits.pop_front();
            if (color !== h.color)
            begin
                $error("color expected %h actual %h", h.color, color);
                errors++;
            end
            if (depth !== h.depth)
            begin
                $error("depth expected %0d actual %0d", h.depth, depth);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  voxel_x;
    logic [6:0]  voxel_y;
    logic [7:0]  voxel_z;
    logic [23:0] voxel_value;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        done;
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;

    ray_scoreboard sb;
    int            gap_pct;

    voxel_ray_cast_first_hit_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .voxel_x(voxel_x), .voxel_y(voxel_y),
        .voxel_z(voxel_z), .voxel_value(voxel_value), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .color(color),
        .depth(depth)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(color, depth);
    end

    task automatic send(cmd_t c);
        start       <= 1'b1;
        action      <= c.act;
        pixel_x     <= c.px;
        pixel_y     <= c.py;
        voxel_x     <= c.vx;
        voxel_y     <= c.vy;
        voxel_z     <= c.vz;
        voxel_value <= c.val;
        do
            @(posedge clk);
        while (busy);
        sb.note(c);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.act = 1'($urandom_range(1));
        c.px  = 8'($urandom);
        c.py  = 8'($urandom);
        c.vx  = 8'($urandom);
        c.vy  = 7'($urandom);
        c.vz  = 8'($urandom);
        c.val = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom);
        return c;
    endfunction

    task automatic cast(logic [7:0] px, logic [7:0] py);
        cmd_t c;
        c = rand_cmd();
        c.act = ACT_CAST;
        c.px = px;
        c.py = py;
        send(c);
    endtask

    task automatic put_voxel(int x, int y, int z, logic [23:0] v);
        cmd_t c;
        c = rand_cmd();
        c.act = ACT_WRITE;
        c.vx = 8'(x);
        c.vy = 7'(y);
        c.vz = 8'(z);
        c.val = v;
        send(c);
    endtask

    // Places a voxel on the ray of a pixel at step k, then casts that ray.
    task automatic aimed_cast(logic [7:0] px, logic [7:0] py, int k, logic [23:0] v);
        int pos[3];
        if (sb.cell_at(px, py, k, pos))
            put_voxel(pos[0], pos[1], pos[2], v);
        cast(px, py);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_hits.size() != 0);
    endtask

    task automatic set_eye(logic [7:0] ex, logic [7:0] ey, logic [7:0] ez);
        logic [7:0] v[3];
        v[0] = ex;
        v[1] = ey;
        v[2] = ez;
        drain();
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= v[i];
            sb.eye[i] = v[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int pct, bit hold);
        gap_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            if (hold && i == n / 2)
                drain();
            if ($urandom_range(99) < 60)
                aimed_cast(8'($urandom), 8'($urandom), int'($urandom_range(0, 320)),
                           24'($urandom) | 24'd1);
            else
                send(rand_cmd());
        end
    endtask

    initial
    begin
        sb = new();
        gap_pct     = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_CAST;
        pixel_x     = '0;
        pixel_y     = '0;
        voxel_x     = '0;
        voxel_y     = '0;
        voxel_z     = '0;
        voxel_value = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_EYE_X;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        cast(8'd128, 8'd176);
        cast(8'd0, 8'd0);
        cast(8'd255, 8'd255);
        cast(8'd0, 8'd255);
        cast(8'd255, 8'd0);
        aimed_cast(8'd10, 8'd20, 50, 24'hFFFFFF);
        put_voxel(128, 80, 120, 24'hFFFFFF);
        cast(8'd200, 8'd100);
        put_voxel(128, 80, 120, 24'h000000);
        cast(8'd200, 8'd100);
        put_voxel(255, 127, 255, 24'h000001);
        put_voxel(0, 0, 0, 24'h800000);

        set_eye(8'd5, 8'd1, 8'd0);
        cast(8'd5, 8'd255);
        put_voxel(5, 1, 0, 24'h123456);
        cast(8'd5, 8'd255);
        cast(8'd0, 8'd128);

        set_eye(8'd255, 8'd255, 8'd255);
        cast(8'd3, 8'd7);
        set_eye(8'd0, 8'd0, 8'd0);
        cast(8'd255, 8'd0);
        cast(8'd0, 8'd255);

        set_eye(8'd128, 8'd80, 8'd120);
        random_phase(85, 0, 0);
        set_eye(8'($urandom), 8'($urandom_range(0, 127)), 8'($urandom));
        random_phase(85, 79, 1);
        set_eye(8'd255, 8'd127, 8'd255);
        random_phase(70, 0, 0);
        set_eye(8'd0, 8'd0, 8'd255);
        random_phase(70, 7, 0);
        set_eye(8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(70, 79, 0);
        set_eye(8'($urandom), 8'($urandom_range(0, 127)), 8'($urandom_range(0, 40)));
        random_phase(60, 0, 0);

        drain();
        repeat (1500) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/vrc_pkg.sv
hdl/vrc_norm.sv
hdl/voxel_ray_cast_first_hit_top.sv
test/voxel_ray_cast_first_hit_top_tb.sv
